### hdl/b64sd_pkg.sv
// ---------------------------------------------------------------------------
// b64sd_pkg
// Shared types, codes and the character map for the base64 stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

    // default width of the per-stream byte counter
    localparam int LENGTH_BITS_DEF = 32;

    // result queue: most results one character can cause, and queue depth
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 8;

    // register indexes of the configuration port
    localparam logic CFG_ALPHABET_SELECT = 1'b0;
    localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

    // special codes from the character map
    localparam logic [7:0] CODE_SKIP = 8'd253;
    localparam logic [7:0] CODE_PAD  = 8'd254;
    localparam logic [7:0] CODE_BAD  = 8'd255;

    // sextet values of the two alphabet-specific characters
    localparam logic [7:0] CODE_62 = 8'd62;
    localparam logic [7:0] CODE_63 = 8'd63;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // one result item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_status;
        logic [1:0]  status_code;
        logic [31:0] decoded_length;
        logic        end_of_run;
    } t_result;

    // map one character to a sextet value or a special code
    function automatic logic [7:0] map_char(input logic [7:0] ch, input logic url_safe);
        logic [7:0] code;
        code = CODE_BAD;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            code = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            code = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            code = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h3D) begin
            code = CODE_PAD;
        end else if (ch == 8'h09 || ch == 8'h0A || ch == 8'h0D || ch == 8'h20) begin
            code = CODE_SKIP;
        end else if (url_safe) begin
            if (ch == 8'h2D) begin
                code = CODE_62;
            end else if (ch == 8'h5F) begin
                code = CODE_63;
            end
        end else begin
            if (ch == 8'h2B) begin
                code = CODE_62;
            end else if (ch == 8'h2F) begin
                code = CODE_63;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### hdl/base64_stream_decoder_unit.sv
// ---------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 decoder taking one encoded character per request, with a queue
// that hands out decoded bytes and one closing status per stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_char_code and i_last_char. A
//   request is taken when i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with one result per transfer: a decoded
//   byte, or (o_is_status high) the status code and decoded length that
//   close the stream. o_end_of_run marks the last result of one character.
//   Each character is decoded in the cycle it is taken and its zero to four
//   results are written into an eight-entry result queue, whose head
//   drives the output combinationally.
//   Throughput: one character per cycle while the queue has room for four
//   results; unless stalled, the output drains one result per cycle, which
//   is the limit (about three bytes per four characters, plus one status
//   per stream). When the receiver stalls, the queue fills and o_stall
//   rises once fewer than four entries are free.
//   Reset (synchronous, active low) empties the queue, clears all stream
//   state and returns the registers to the standard alphabet and a full
//   capacity. Users must write registers via i_cfg_we while idle (unenforced).
// ---------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit #(
    parameter int LENGTH_BITS = b64sd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // character input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_char,
    // result output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_data_byte,
    output logic             o_is_status,
    output logic [1:0]       o_status_code,
    output logic [31:0]      o_decoded_length,
    output logic             o_end_of_run
);

    import b64sd_pkg::*;

    localparam int CW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam int RW = $clog2(MAX_RESULTS);

    // registers
    logic                   r_alphabet_select;
    logic [31:0]            r_output_capacity;

    // stream state
    logic [17:0]            r_bit_acc,   n_bit_acc;
    logic [1:0]             r_sext_cnt,  n_sext_cnt;
    logic [1:0]             r_pad_cnt,   n_pad_cnt;
    logic [1:0]             r_raw_cnt,   n_raw_cnt;
    logic [LENGTH_BITS-1:0] r_bytes_out, n_bytes_out;
    logic [1:0]             r_error,     n_error;

    // result queue
    t_result                r_queue [QUEUE_DEPTH];
    logic [PW-1:0]          r_wr_ptr;
    logic [PW-1:0]          r_rd_ptr;
    logic [PW:0]            r_count;

    // results of the current character
    t_result                n_res [MAX_RESULTS];
    logic [NW-1:0]          n_res_cnt;

    logic                   in_accept;
    logic                   out_accept;

    assign o_stall    = (r_count > (PW+1)'(QUEUE_DEPTH - MAX_RESULTS));
    assign in_accept  = i_valid && !o_stall;
    assign o_valid    = (r_count != '0);
    assign out_accept = o_valid && !i_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_select <= 1'b0;
            r_output_capacity <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHABET_SELECT: r_alphabet_select <= i_cfg_data[0];
                CFG_OUTPUT_CAPACITY: r_output_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode one character into stream state and results
    always_comb begin
        logic [7:0]    code;
        logic [CW-1:0] lim;
        logic [CW-1:0] len_max;
        logic [CW-1:0] cap_ext;
        logic [CW-1:0] bytes_ext;
        logic [23:0]   group;
        logic [NW-1:0] cnt;
        t_result       blank;

        blank       = '0;
        n_bit_acc   = r_bit_acc;
        n_sext_cnt  = r_sext_cnt;
        n_pad_cnt   = r_pad_cnt;
        n_raw_cnt   = r_raw_cnt + 2'd1;
        n_bytes_out = r_bytes_out;
        n_error     = r_error;
        cnt         = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_res[k] = blank;
        end

        code      = map_char(i_char_code, r_alphabet_select);
        len_max   = CW'({LENGTH_BITS{1'b1}});
        cap_ext   = CW'(r_output_capacity);
        lim       = (cap_ext < len_max) ? cap_ext : len_max;
        group     = {r_bit_acc, code[5:0]};
        bytes_ext = CW'(r_bytes_out);

        // character step
        if (r_error == ST_OK) begin
            if (code == CODE_PAD) begin
                if (r_pad_cnt != 2'd3) begin
                    n_pad_cnt = r_pad_cnt + 2'd1;
                end
            end else if (code == CODE_SKIP) begin
                n_pad_cnt = r_pad_cnt;
            end else if (code == CODE_BAD || r_pad_cnt != 2'd0) begin
                n_error = ST_INVALID;
            end else if (r_sext_cnt == 2'd3) begin
                if (bytes_ext + CW'(3) > lim) begin
                    n_error = ST_OVERFLOW;
                end else begin
                    n_res[0].data_byte = group[23:16];
                    n_res[1].data_byte = group[15:8];
                    n_res[2].data_byte = group[7:0];
                    cnt                = NW'(3);
                    n_bytes_out        = r_bytes_out + LENGTH_BITS'(3);
                end
                n_bit_acc  = '0;
                n_sext_cnt = '0;
            end else begin
                n_bit_acc  = {r_bit_acc[11:0], code[5:0]};
                n_sext_cnt = r_sext_cnt + 2'd1;
            end
        end

        // end of stream: partial group, padding check, status
        if (i_last_char) begin
            bytes_ext = CW'(n_bytes_out);
            if (n_error == ST_OK && n_sext_cnt != 2'd0) begin
                if (n_sext_cnt == 2'd1) begin
                    n_error = ST_INVALID;
                end else if (bytes_ext + CW'(n_sext_cnt - 2'd1) > lim) begin
                    n_error = ST_OVERFLOW;
                end else if (n_sext_cnt == 2'd2) begin
                    n_res[cnt[RW-1:0]].data_byte = n_bit_acc[11:4];
                    cnt                          = cnt + NW'(1);
                    n_bytes_out                  = n_bytes_out + LENGTH_BITS'(1);
                end else begin
                    n_res[cnt[RW-1:0]].data_byte = n_bit_acc[17:10];
                    cnt                          = cnt + NW'(1);
                    n_res[cnt[RW-1:0]].data_byte = n_bit_acc[9:2];
                    cnt                          = cnt + NW'(1);
                    n_bytes_out                  = n_bytes_out + LENGTH_BITS'(2);
                end
            end
            if (n_error == ST_OK &&
                (n_pad_cnt > 2'd2 || (n_pad_cnt != 2'd0 && n_raw_cnt != 2'd0))) begin
                n_error = ST_INVALID;
            end
            bytes_ext                         = CW'(n_bytes_out);
            n_res[cnt[RW-1:0]].is_status      = 1'b1;
            n_res[cnt[RW-1:0]].status_code    = n_error;
            n_res[cnt[RW-1:0]].decoded_length = bytes_ext[31:0];
            cnt                               = cnt + NW'(1);
            // stream closed
            n_bit_acc   = '0;
            n_sext_cnt  = '0;
            n_pad_cnt   = '0;
            n_raw_cnt   = '0;
            n_bytes_out = '0;
            n_error     = ST_OK;
        end

        // mark the last result of this character
        if (cnt != '0) begin
            n_res[RW'(cnt - NW'(1))].end_of_run = 1'b1;
        end
        n_res_cnt = cnt;
    end

    // stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_acc   <= '0;
            r_sext_cnt  <= '0;
            r_pad_cnt   <= '0;
            r_raw_cnt   <= '0;
            r_bytes_out <= '0;
            r_error     <= ST_OK;
        end else if (in_accept) begin
            r_bit_acc   <= n_bit_acc;
            r_sext_cnt  <= n_sext_cnt;
            r_pad_cnt   <= n_pad_cnt;
            r_raw_cnt   <= n_raw_cnt;
            r_bytes_out <= n_bytes_out;
            r_error     <= n_error;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + PW'(n_res_cnt);
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + ((in_accept) ? (PW+1)'(n_res_cnt) : '0)
                               - ((out_accept) ? (PW+1)'(1) : '0);
        end
    end

    // result queue entries
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (NW'(k) < n_res_cnt) begin
                    r_queue[r_wr_ptr + PW'(k)] <= n_res[k];
                end
            end
        end
    end

    // head of queue drives the output
    assign o_data_byte      = r_queue[r_rd_ptr].data_byte;
    assign o_is_status      = r_queue[r_rd_ptr].is_status;
    assign o_status_code    = r_queue[r_rd_ptr].status_code;
    assign o_decoded_length = r_queue[r_rd_ptr].decoded_length;
    assign o_end_of_run     = r_queue[r_rd_ptr].end_of_run;

endmodule

`default_nettype wire
